// ===== rtl/core/sobel_edge_magnitude_rgb_core_macros.svh =====
// assertion macros shared by the sobel edge core
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SEMRGB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SEMRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/semrgb_pkg.sv =====
// types, constants and register codes for the sobel edge magnitude core
`timescale 1ns / 1ps

package semrgb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W        = 8;
    localparam int NUM_LANES    = 3;
    localparam int RGB_W        = PIX_W * NUM_LANES;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_BIT  = 2;

    // gradient magnitude per axis, square sum and root
    localparam int GRAD_W = 10;
    localparam int SQ_W   = 2 * GRAD_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = 8;
    localparam int BIT_W  = 3;

    localparam logic [SUM_W-1:0]  SAT_LIMIT = SUM_W'(65281);
    localparam logic [ROOT_W-1:0] SAT_VALUE = ROOT_W'(255);

    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = CFG_HEIGHT_W'(480);

    // register indexes on the config port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_WAIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_SQUARE,
        LN_ROOT,
        LN_ROUND,
        LN_DONE
    } lane_state_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    typedef struct packed {
        logic start;
        logic take;
    } lane_ctrl_t;

    // one channel of the 3x3 window, [row][column]
    typedef logic [2:0][2:0][PIX_W-1:0] chan_win_t;

endpackage

// ===== rtl/core/semrgb_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module semrgb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/semrgb_lane.sv =====
// one color channel: sobel gradients, square sum and rounded square root
`timescale 1ns / 1ps

module semrgb_lane
    import semrgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  border_t           border,
    input  chan_win_t         win,
    output logic              done,
    output logic [ROOT_W-1:0] result
);

    lane_state_t state_reg, state_next;

    logic [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              sat_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [2*ROOT_W-1:0] rsq_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [ROOT_W-1:0] result_reg;

    chan_win_t         masked;
    logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y, gx_next, gy_next;
    logic [SQ_W-1:0]   sq_x, sq_y;
    logic [SUM_W-1:0]  sum_next;
    logic [ROOT_W-1:0] trial;
    logic [2*ROOT_W-1:0] trial_sq;
    logic [2*ROOT_W:0] round_lim;

    // neighbors outside the frame read as zero
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && border.top) || (r == 2 && border.bottom) ||
                    (c == 0 && border.left) || (c == 2 && border.right))
                begin
                    masked[r][c] = '0;
                end
                else
                begin
                    masked[r][c] = win[r][c];
                end
            end
        end
    end

    assign pos_x = GRAD_W'(masked[0][2]) + GRAD_W'({masked[1][2], 1'b0}) + GRAD_W'(masked[2][2]);
    assign neg_x = GRAD_W'(masked[0][0]) + GRAD_W'({masked[1][0], 1'b0}) + GRAD_W'(masked[2][0]);
    assign pos_y = GRAD_W'(masked[2][0]) + GRAD_W'({masked[2][1], 1'b0}) + GRAD_W'(masked[2][2]);
    assign neg_y = GRAD_W'(masked[0][0]) + GRAD_W'({masked[0][1], 1'b0}) + GRAD_W'(masked[0][2]);

    // only the magnitude of each gradient matters for the square
    assign gx_next = (pos_x >= neg_x) ? (pos_x - neg_x) : (neg_x - pos_x);
    assign gy_next = (pos_y >= neg_y) ? (pos_y - neg_y) : (neg_y - pos_y);

    assign sq_x     = {{GRAD_W{1'b0}}, gx_reg} * {{GRAD_W{1'b0}}, gx_reg};
    assign sq_y     = {{GRAD_W{1'b0}}, gy_reg} * {{GRAD_W{1'b0}}, gy_reg};
    assign sum_next = {1'b0, sq_x} + {1'b0, sq_y};

    assign trial     = root_reg | (ROOT_W'(1) << bit_reg);
    assign trial_sq  = {{ROOT_W{1'b0}}, trial} * {{ROOT_W{1'b0}}, trial};
    assign round_lim = {1'b0, rsq_reg} + (2*ROOT_W+1)'(root_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = LN_SQUARE;
                end
            end
            LN_SQUARE:
            begin
                state_next = LN_ROOT;
            end
            LN_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = LN_ROUND;
                end
            end
            LN_ROUND:
            begin
                state_next = LN_DONE;
            end
            LN_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = LN_IDLE;
                end
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LN_IDLE:
            begin
                gx_reg <= gx_next;
                gy_reg <= gy_next;
            end
            LN_SQUARE:
            begin
                sum_reg  <= sum_next;
                sat_reg  <= (sum_next >= SAT_LIMIT);
                root_reg <= '0;
                rsq_reg  <= '0;
                bit_reg  <= BIT_W'(ROOT_W - 1);
            end
            LN_ROOT:
            begin
                // one result bit per cycle, most significant first
                if (SUM_W'(trial_sq) <= sum_reg)
                begin
                    root_reg <= trial;
                    rsq_reg  <= trial_sq;
                end
                bit_reg <= bit_reg - BIT_W'(1);
            end
            LN_ROUND:
            begin
                if (sat_reg)
                begin
                    result_reg <= SAT_VALUE;
                end
                else if (sum_reg > SUM_W'(round_lim))
                begin
                    result_reg <= root_reg + ROOT_W'(1);
                end
                else
                begin
                    result_reg <= root_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == LN_DONE);
    assign result = result_reg;

endmodule

// ===== rtl/core/semrgb_merge.sv =====
// output stage: gathers the three lane results into one result item
`timescale 1ns / 1ps

module semrgb_merge
    import semrgb_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [NUM_LANES-1:0][PIX_W-1:0]  lane_result,
    input  logic                             last,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [PIX_W-1:0]                 edge_red,
    output logic [PIX_W-1:0]                 edge_green,
    output logic [PIX_W-1:0]                 edge_blue,
    output logic                             frame_end,
    output logic                             free
);

    logic                            out_valid_reg;
    logic [NUM_LANES-1:0][PIX_W-1:0] result_reg;
    logic                            frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg    <= lane_result;
            frame_end_reg <= last;
        end
    end

    // the slot frees up in the same cycle that the waiting item is taken
    assign free       = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign edge_red   = result_reg[0];
    assign edge_green = result_reg[1];
    assign edge_blue  = result_reg[2];
    assign frame_end  = frame_end_reg;

endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb_core.sv =====
// top level: sobel edge magnitude per rgb channel over a raster pixel stream
// an item that yields a result passes window shift, gradients, square sum,
// 8-step lane root and rounding, then waits for a free output slot; the next
// item waits for that load, which sets out_valid; with no result, for the shift
// reset: frame 640x480, counters and window zero, line ram contents left as is
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_core_macros.svh"

module sobel_edge_magnitude_rgb_core
    import semrgb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pix_red,
    input  logic [PIX_W-1:0]      pix_green,
    input  logic [PIX_W-1:0]      pix_blue,
    input  logic                  flush,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      edge_red,
    output logic [PIX_W-1:0]      edge_green,
    output logic [PIX_W-1:0]      edge_blue,
    output logic                  frame_end
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int OUT_ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WMAX_W    = $clog2(MAX_WIDTH + 1);
    localparam int WSZ_W     = (WMAX_W > CFG_WIDTH_W) ? WMAX_W : CFG_WIDTH_W;
    localparam int HSZ_W     = (IN_ROW_W > CFG_HEIGHT_W) ? IN_ROW_W : CFG_HEIGHT_W;

    // configuration registers
    logic [CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [CFG_HEIGHT_W-1:0] frame_height_reg;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[REG_IDX_BIT])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_IDX_BIT])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // effective frame size: zero reads as one, large values clamp
    logic [WSZ_W-1:0] w_size;
    logic [HSZ_W-1:0] h_size;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_size = WSZ_W'(1);
        end
        else if (WSZ_W'(frame_width_reg) > WSZ_W'(MAX_WIDTH))
        begin
            w_size = WSZ_W'(MAX_WIDTH);
        end
        else
        begin
            w_size = WSZ_W'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_size = HSZ_W'(1);
        end
        else if (HSZ_W'(frame_height_reg) > HSZ_W'(MAX_HEIGHT))
        begin
            h_size = HSZ_W'(MAX_HEIGHT);
        end
        else
        begin
            h_size = HSZ_W'(frame_height_reg);
        end
    end

    // position counters
    logic [COL_W-1:0]     in_column_reg, out_column_reg;
    logic [IN_ROW_W-1:0]  in_row_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;

    ctl_state_t state_reg, state_next;

    logic    in_fire, draining, process, item_valid, col_wrap, item_last;
    border_t item_border;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign draining = (HSZ_W'(in_row_reg) >= h_size);
    // a pixel while draining, or a flush mid-frame, changes nothing
    assign process  = (flush == draining);

    assign item_valid = (in_row_reg >= IN_ROW_W'(2)) ||
                        ((in_row_reg == IN_ROW_W'(1)) && (in_column_reg != '0));
    assign col_wrap   = (WSZ_W'(in_column_reg) + WSZ_W'(1) >= w_size);

    assign item_border.top    = (out_row_reg == '0);
    assign item_border.bottom = (HSZ_W'(out_row_reg) + HSZ_W'(1) >= h_size);
    assign item_border.left   = (out_column_reg == '0);
    assign item_border.right  = (WSZ_W'(out_column_reg) + WSZ_W'(1) >= w_size);
    assign item_last          = item_border.bottom && item_border.right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else if (in_fire && process)
        begin
            if (item_valid && item_last)
            begin
                in_column_reg  <= '0;
                in_row_reg     <= '0;
                out_column_reg <= '0;
                out_row_reg    <= '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    in_column_reg <= '0;
                    in_row_reg    <= in_row_reg + IN_ROW_W'(1);
                end
                else
                begin
                    in_column_reg <= in_column_reg + COL_W'(1);
                end
                if (item_valid)
                begin
                    if (item_border.right)
                    begin
                        out_column_reg <= '0;
                        out_row_reg    <= out_row_reg + OUT_ROW_W'(1);
                    end
                    else
                    begin
                        out_column_reg <= out_column_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // item held while it moves through the window and the lanes
    logic [RGB_W-1:0] px_reg;
    logic [COL_W-1:0] col_reg;
    logic             par_reg;
    logic             valid_reg;
    logic             last_reg;
    border_t          border_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && process)
        begin
            px_reg     <= flush ? '0 : {pix_red, pix_green, pix_blue};
            col_reg    <= in_column_reg;
            par_reg    <= in_row_reg[0];
            valid_reg  <= item_valid;
            last_reg   <= item_last;
            border_reg <= item_border;
        end
    end

    // two line rams, one per row parity; each slot is read then rewritten
    logic [RGB_W-1:0] ram_rd_data [2];

    for (genvar p = 0; p < 2; p++)
    begin : g_line
        semrgb_ram #(
            .WIDTH (RGB_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .clk     (clk),
            .wr_en   ((state_reg == ST_SHIFT) && (par_reg == 1'(p))),
            .wr_addr (col_reg),
            .wr_data (px_reg),
            .rd_en   (in_fire && process),
            .rd_addr (in_column_reg),
            .rd_data (ram_rd_data[p])
        );
    end

    logic [RGB_W-1:0] older, newer;

    assign older = par_reg ? ram_rd_data[1] : ram_rd_data[0];
    assign newer = par_reg ? ram_rd_data[0] : ram_rd_data[1];

    // 3x3 window, [row][column], column 2 is the newest
    logic [RGB_W-1:0] win_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (state_reg == ST_SHIFT)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= older;
            win_reg[1][2] <= newer;
            win_reg[2][2] <= px_reg;
        end
    end

    // control sequencer
    logic                            out_free;
    logic                            lane_take;
    lane_ctrl_t                      lane_ctrl;
    logic [NUM_LANES-1:0]            lane_done;
    logic [NUM_LANES-1:0][PIX_W-1:0] lane_result;
    chan_win_t                       lane_win [NUM_LANES];

    assign lane_take       = (state_reg == ST_WAIT) && (&lane_done) && out_free;
    assign lane_ctrl.start = (state_reg == ST_GRAD);
    assign lane_ctrl.take  = lane_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && process)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = valid_reg ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (lane_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // lane 0 red, lane 1 green, lane 2 blue
    for (genvar ch = 0; ch < NUM_LANES; ch++)
    begin : g_lane
        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lane_win[ch][r][c] = win_reg[r][c][PIX_W*(NUM_LANES-1-ch) +: PIX_W];
                end
            end
        end

        semrgb_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .border (border_reg),
            .win    (lane_win[ch]),
            .done   (lane_done[ch]),
            .result (lane_result[ch])
        );
    end

    semrgb_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (lane_take),
        .lane_result (lane_result),
        .last        (last_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .edge_red    (edge_red),
        .edge_green  (edge_green),
        .edge_blue   (edge_blue),
        .frame_end   (frame_end),
        .free        (out_free)
    );

    logic frame_restart, counters_zero;

    assign frame_restart = in_fire && process && item_valid && item_last;
    assign counters_zero = (in_row_reg == '0) && (out_row_reg == '0) &&
                           (in_column_reg == '0) && (out_column_reg == '0);

    `SEMRGB_ASSERT_NOW(a_lanes_lockstep, (|lane_done), (&lane_done), "lanes out of step")
    `SEMRGB_ASSERT_NOW(a_busy_no_accept, (|lane_done), !in_ready, "item taken while lanes busy")
    `SEMRGB_ASSERT_NEXT(a_result_loaded, lane_take, out_valid, "lane result not presented")
    `SEMRGB_ASSERT_NEXT(a_frame_restart, frame_restart, counters_zero, "counters kept at frame end")

endmodule

// ===== tb/sobel_edge_magnitude_rgb_core_test.sv =====
// testbench for the sobel edge core: raster frames of random pixels checked against a predictor
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_core_test;
    import semrgb_pkg::*;

    localparam int BUSY_CYCLES = 20;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SAT_SUM     = 65281;

    typedef enum logic [1:0] {
        PACE_RX_HEAVY,
        PACE_TX_HEAVY,
        PACE_NONE
    } pace_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             flush;
        pace_t            pace;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } edge_px_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pix_red = '0;
    logic [PIX_W-1:0]      pix_green = '0;
    logic [PIX_W-1:0]      pix_blue = '0;
    logic                  flush = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      edge_red;
    logic [PIX_W-1:0]      edge_green;
    logic [PIX_W-1:0]      edge_blue;
    logic                  frame_end;

    pix_item_t pending[$];
    edge_px_t  edge_q[$];
    pace_t     pace_now = PACE_RX_HEAVY;
    bit        in_taken = 1'b0;

    int cycles = 0;
    int errors = 0;
    int items_taken = 0;
    int edges_checked = 0;
    int frames = 0;
    int frame_items = 0;

    // predictor state
    logic [CFG_WIDTH_W-1:0]  shadow_width = FRAME_WIDTH_RST;
    logic [CFG_HEIGHT_W-1:0] shadow_height = FRAME_HEIGHT_RST;
    logic [RGB_W-1:0]        line_mem [0:2*MAX_WIDTH_DEF-1];
    logic [RGB_W-1:0]        win [0:2][0:2];
    int unsigned             feed_col = 0;
    int unsigned             feed_row = 0;
    int unsigned             emit_col = 0;
    int unsigned             emit_row = 0;

    sobel_edge_magnitude_rgb_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pix_red    (pix_red),
        .pix_green  (pix_green),
        .pix_blue   (pix_blue),
        .flush      (flush),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_red   (edge_red),
        .edge_green (edge_green),
        .edge_blue  (edge_blue),
        .frame_end  (frame_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_pct(pace_t p, bit rx);
        case (p)
            PACE_RX_HEAVY: return rx ? 67 : 28;
            PACE_TX_HEAVY: return rx ? 28 : 67;
            default:       return 0;
        endcase
    endfunction

    // rounded, saturated gradient length of one color lane of the window
    function automatic logic [PIX_W-1:0] lane_edge(int lsb, bit top, bit bottom, bit left,
                                                  bit right);
        int gx;
        int gy;
        int v;
        int s;
        int f;
        int t;
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 0 && top) || (r == 2 && bottom) || (c == 0 && left) ||
                      (c == 2 && right)))
                begin
                    v = win[r][c][lsb +: PIX_W];
                    gx += v * (c - 1) * ((r == 1) ? 2 : 1);
                    gy += v * (r - 1) * ((c == 1) ? 2 : 1);
                end
            end
        end
        s = gx * gx + gy * gy;
        if (s >= SAT_SUM)
            return 8'hFF;
        f = 0;
        for (int b = 7; b >= 0; b--)
        begin
            t = f | (1 << b);
            if (t * t <= s)
                f = t;
        end
        if (s > f * f + f)
            f++;
        return 8'(f);
    endfunction

    task automatic predict_edges(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                 input logic [PIX_W-1:0] b, input logic fl);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned par;
        logic [RGB_W-1:0] px;
        bit draining;
        bit produce;
        bit top;
        bit bottom;
        bit left;
        bit right;
        edge_px_t e;
        w = (shadow_width == 0) ? 1 :
            (shadow_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : shadow_width;
        h = (shadow_height == 0) ? 1 :
            (shadow_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : shadow_height;
        draining = feed_row >= h;
        // a flush counts only while draining, a pixel only while not
        if (fl == draining)
        begin
            px = fl ? '0 : {r, g, b};
            col = feed_col % MAX_WIDTH_DEF;
            par = feed_row & 1;
            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = line_mem[par * MAX_WIDTH_DEF + col];
            win[1][2] = line_mem[(par ^ 1) * MAX_WIDTH_DEF + col];
            win[2][2] = px;
            line_mem[par * MAX_WIDTH_DEF + col] = px;
            produce = feed_row >= 2 || (feed_row == 1 && feed_col >= 1);
            if (feed_col + 1 >= w)
            begin
                feed_col = 0;
                feed_row++;
            end
            else
                feed_col++;
            if (produce)
            begin
                top = emit_row == 0;
                bottom = emit_row + 1 >= h;
                left = emit_col == 0;
                right = emit_col + 1 >= w;
                e.red = lane_edge(2 * PIX_W, top, bottom, left, right);
                e.green = lane_edge(PIX_W, top, bottom, left, right);
                e.blue = lane_edge(0, top, bottom, left, right);
                e.last = bottom && right;
                edge_q.push_back(e);
                if (e.last)
                begin
                    feed_col = 0;
                    feed_row = 0;
                    emit_col = 0;
                    emit_row = 0;
                end
                else if (right)
                begin
                    emit_col = 0;
                    emit_row++;
                end
                else
                    emit_col++;
            end
        end
    endtask

    function automatic logic [PIX_W-1:0] rand_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_item(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic fl, input pace_t p);
        pix_item_t it;
        it.red = r;
        it.green = g;
        it.blue = b;
        it.flush = fl;
        it.pace = p;
        pending.push_back(it);
    endtask

    // one frame in raster order plus its drain, optionally with stray items
    task automatic queue_frame(input int w, input int h, input bit noisy, input pace_t p);
        int stray;
        int late;
        stray = noisy ? $urandom_range(w * h - 1) : -1;
        late = noisy ? $urandom_range(w) : -1;
        for (int n = 0; n < w * h; n++)
        begin
            if (n == stray)
                push_item(rand_level(), rand_level(), rand_level(), 1'b1, p);
            push_item(rand_level(), rand_level(), rand_level(), 1'b0, p);
        end
        for (int n = 0; n <= w; n++)
        begin
            if (n == late)
                push_item(rand_level(), rand_level(), rand_level(), 1'b0, p);
            push_item(rand_level(), rand_level(), rand_level(), 1'b1, p);
        end
        if (noisy)
            repeat ($urandom_range(1, 2))
                push_item(rand_level(), rand_level(), rand_level(), 1'b1, p);
        frame_items += w * h + w + 1;
    endtask

    task automatic settle();
        while (pending.size() != 0 || in_valid || edge_q.size() != 0)
            @(posedge clk);
        repeat (BUSY_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << REG_IDX_BIT;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_FRAME_WIDTH)
            shadow_width = value[CFG_WIDTH_W-1:0];
        else
            shadow_height = value[CFG_HEIGHT_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_random(input pace_t p, input int count);
        int goal;
        int w;
        int h;
        bit resize;
        goal = frame_items + count;
        resize = 1'b1;
        w = 1;
        h = 1;
        while (frame_items < goal)
        begin
            if (resize)
            begin
                settle();
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 6);
                write_reg(REG_FRAME_WIDTH, w);
                write_reg(REG_FRAME_HEIGHT, h);
            end
            queue_frame(w, h, $urandom_range(3) == 0, p);
            resize = $urandom_range(1);
        end
    endtask

    always @(negedge clk)
    begin : drive
        pix_item_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending.size() != 0 &&
                $urandom_range(99) >= idle_pct(pending[0].pace, 1'b0))
            begin
                nxt = pending.pop_front();
                in_valid <= 1'b1;
                pix_red <= nxt.red;
                pix_green <= nxt.green;
                pix_blue <= nxt.blue;
                flush <= nxt.flush;
                pace_now <= nxt.pace;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= $urandom_range(99) >= idle_pct(pace_now, 1'b1);
    end

    always @(posedge clk)
    begin : observe
        edge_px_t seen;
        edge_px_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.red = edge_red;
                seen.green = edge_green;
                seen.blue = edge_blue;
                seen.last = frame_end;
                if (edge_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: edge pixel with none expected: r=%0d g=%0d b=%0d end=%0b",
                             $time, seen.red, seen.green, seen.blue, seen.last);
                end
                else
                begin
                    want = edge_q.pop_front();
                    edges_checked++;
                    if (seen != want)
                    begin
                        errors++;
                        $display("%0t: expected %0d %0d %0d end %0b, got %0d %0d %0d end %0b",
                                 $time, want.red, want.green, want.blue, want.last,
                                 seen.red, seen.green, seen.blue, seen.last);
                    end
                    if (want.last)
                        frames++;
                end
            end
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                items_taken++;
                predict_edges(pix_red, pix_green, pix_blue, flush);
            end
        end
    end

    initial
    begin
        for (int k = 0; k < 2 * MAX_WIDTH_DEF; k++)
            line_mem[k] = '0;
        for (int k = 0; k < 9; k++)
            win[k / 3][k % 3] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hard edges, stray flush mid-frame, pixel during drain, one extra flush
        settle();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 2);
        push_item(8'hFF, 8'h00, 8'h80, 1'b0, PACE_RX_HEAVY);
        push_item(8'h00, 8'hFF, 8'h7F, 1'b0, PACE_RX_HEAVY);
        push_item(8'hFF, 8'hFF, 8'h01, 1'b0, PACE_RX_HEAVY);
        push_item(8'hA5, 8'h5A, 8'h3C, 1'b1, PACE_RX_HEAVY);
        push_item(8'h00, 8'h00, 8'hFE, 1'b0, PACE_RX_HEAVY);
        push_item(8'hFF, 8'h00, 8'h00, 1'b0, PACE_RX_HEAVY);
        push_item(8'h00, 8'hFF, 8'hFF, 1'b0, PACE_RX_HEAVY);
        push_item(8'h00, 8'h00, 8'h00, 1'b1, PACE_RX_HEAVY);
        push_item(8'hFF, 8'hFF, 8'hFF, 1'b0, PACE_RX_HEAVY);
        repeat (4) push_item(8'hFF, 8'hFF, 8'hFF, 1'b1, PACE_RX_HEAVY);

        // zero sizes act as a single pixel frame
        settle();
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        push_item(8'hC8, 8'h64, 8'h32, 1'b0, PACE_RX_HEAVY);
        repeat (2) push_item(8'h11, 8'h22, 8'h33, 1'b1, PACE_RX_HEAVY);

        // width shrinks in the middle of a frame
        settle();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 2);
        repeat (4) push_item(rand_level(), rand_level(), rand_level(), 1'b0, PACE_RX_HEAVY);
        settle();
        write_reg(REG_FRAME_WIDTH, 2);
        push_item(rand_level(), rand_level(), rand_level(), 1'b0, PACE_RX_HEAVY);
        repeat (4) push_item(rand_level(), rand_level(), rand_level(), 1'b1, PACE_RX_HEAVY);

        // oversized width saturates: the row wraps after the widest line, then a narrow drain
        settle();
        write_reg(REG_FRAME_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 1);
        repeat (MAX_WIDTH_DEF)
            push_item(rand_level(), rand_level(), rand_level(), 1'b0, PACE_RX_HEAVY);
        settle();
        write_reg(REG_FRAME_WIDTH, 2);
        repeat (3) push_item(8'h00, 8'h00, 8'h00, 1'b1, PACE_RX_HEAVY);

        queue_random(PACE_RX_HEAVY, 120);
        queue_random(PACE_TX_HEAVY, 120);
        queue_random(PACE_NONE, 120);

        settle();
        $display("%0d items taken, %0d edge pixels compared over %0d frames",
                 items_taken, edges_checked, frames);
        $display("sizes from one pixel up to the widest row, with stray items and resizes");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/semrgb_pkg.sv
rtl/core/semrgb_ram.sv
rtl/core/semrgb_lane.sv
rtl/core/semrgb_merge.sv
rtl/core/sobel_edge_magnitude_rgb_core.sv
tb/sobel_edge_magnitude_rgb_core_test.sv
